// ===== design/mrww_pkg.sv =====
// ----------------------------------------------------------------------------
// mrww_pkg
// Shared types, constants and helpers for the minimum-raggedness word wrap.
// ----------------------------------------------------------------------------
package mrww_pkg;

    // Field widths fixed by the interface
    localparam int LINE_W_BITS = 11;
    localparam int COST_W      = 32;

    // Default largest line width and register reset value
    localparam int DEF_MAX_WIDTH = 1024;
    localparam logic [LINE_W_BITS-1:0] LINE_WIDTH_RST = LINE_W_BITS'(1024);

    typedef logic [COST_W-1:0] cost_t;

    // All ones marks an unreachable used-cell count
    localparam cost_t COST_UNREACH = '1;

    // Saturating add of two costs
    function automatic cost_t sat_add(input cost_t a, input cost_t b);
        logic [COST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COST_W] ? COST_UNREACH : sum[COST_W-1:0];
    endfunction

    // Smaller of two costs
    function automatic cost_t cost_min(input cost_t a, input cost_t b);
        return (b < a) ? b : a;
    endfunction

endpackage

// ===== design/mrww_cost_bank.sv =====
// ----------------------------------------------------------------------------
// mrww_cost_bank
// One cost table: simple dual-port memory, one write and one registered read.
// ----------------------------------------------------------------------------
module mrww_cost_bank
    import mrww_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH + 1,
    parameter int AW    = $clog2(DEF_MAX_WIDTH + 1)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  cost_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output cost_t         rd_data
);

    cost_t mem [DEPTH];
    cost_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/min_raggedness_word_wrap.sv =====
// ----------------------------------------------------------------------------
// min_raggedness_word_wrap
// Minimum-raggedness line breaking with a forward cost table per used count.
// ----------------------------------------------------------------------------
//
//  channel   signals                              direction  payload
//  word      word_valid / word_stall              in         word_length, last_word
//  result    result_valid / result_stall          out        min_cost, too_long
//  cfg       cfg_write_enable / cfg_write_data    in         line width register
//
// A word reads the current cost table once per used-cell count 0..W, W
// being the width in force, then drains and makes the final write.
// The first word of a text, and a word longer than the line, skip the scan.
// The tables need no clearing after reset: a valid range per table masks
// entries that the previous word did not write.
// word_stall is high while a word is in work; a stalled result holds, and
// the final word of a text waits until the result register is free.
//
module min_raggedness_word_wrap
    import mrww_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write_enable,
    input  logic [LINE_W_BITS-1:0] cfg_write_data,

    input  logic                   word_valid,
    output logic                   word_stall,
    input  logic [LINE_W_BITS-1:0] word_length,
    input  logic                   last_word,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [COST_W-1:0]      min_cost,
    output logic                   too_long
);

    localparam int DEPTH = MAX_WIDTH + 1;
    localparam int AW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = AW + 1;
    localparam int SW    = 2 * AW;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // Control state
    logic [1:0]             state_reg, state_next;
    logic [LINE_W_BITS-1:0] line_width_reg, line_width_next;
    logic                   first_reg, first_next;
    logic                   err_reg, err_next;
    logic                   bank_sel_reg, bank_sel_next;
    logic                   cur_ok_reg, cur_ok_next;
    logic                   s1_valid_reg, s1_valid_next;
    logic                   out_valid_reg, out_valid_next;

    // Working registers
    logic [AW-1:0]          u_reg, u_next;
    logic [AW-1:0]          len_reg, len_next;
    logic                   last_reg, last_next;
    logic                   bad_reg, bad_next;
    logic [AW-1:0]          cur_lo_reg, cur_lo_next;
    logic [AW-1:0]          cur_hi_reg, cur_hi_next;
    cost_t                  brk_min_reg, brk_min_next;
    cost_t                  cont_min_reg, cont_min_next;
    logic [AW-1:0]          s1_u_reg, s1_u_next;
    logic [SW-1:0]          s1_sq_reg, s1_sq_next;
    cost_t                  min_cost_reg, min_cost_next;
    logic                   too_long_reg, too_long_next;

    // Memory ports
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    cost_t                  wr_data;
    logic [AW-1:0]          rd_addr;
    cost_t                  a_rd_data, b_rd_data, rd_data;

    // Datapath helpers
    logic [AW-1:0]          width_eff;
    logic [AW-1:0]          free_cells;
    logic                   word_take;
    logic                   word_bad;
    logic                   out_free;
    logic                   s1_hit;
    cost_t                  s1_cost;
    cost_t                  s1_brk;
    logic [EW-1:0]          s1_target;
    logic                   s1_fits;

    // Width in force, clipped to the table size
    assign width_eff = (32'(line_width_reg) > 32'(MAX_WIDTH)) ? AW'(MAX_WIDTH)
                                                              : AW'(line_width_reg);

    assign word_stall   = (state_reg != ST_IDLE);
    assign word_take    = word_valid && !word_stall;
    assign word_bad     = (32'(word_length) > 32'(width_eff));
    assign out_free     = !out_valid_reg || !result_stall;

    assign free_cells   = width_eff - u_reg;

    // Second stage: table data arrives, mask entries outside the valid range
    assign rd_data   = bank_sel_reg ? b_rd_data : a_rd_data;
    assign s1_hit    = cur_ok_reg && (s1_u_reg >= cur_lo_reg) && (s1_u_reg <= cur_hi_reg);
    assign s1_cost   = s1_hit ? rd_data : COST_UNREACH;
    assign s1_brk    = sat_add(s1_cost, COST_W'(s1_sq_reg));
    assign s1_target = EW'(s1_u_reg) + EW'(1) + EW'(len_reg);
    assign s1_fits   = (s1_target <= EW'(width_eff));

    assign rd_addr = u_reg;

    // Next-state and datapath
    always_comb
    begin
        state_next      = state_reg;
        line_width_next = line_width_reg;
        first_next      = first_reg;
        err_next        = err_reg;
        bank_sel_next   = bank_sel_reg;
        cur_ok_next     = cur_ok_reg;
        out_valid_next  = out_valid_reg;
        u_next          = u_reg;
        len_next        = len_reg;
        last_next       = last_reg;
        bad_next        = bad_reg;
        cur_lo_next     = cur_lo_reg;
        cur_hi_next     = cur_hi_reg;
        brk_min_next    = brk_min_reg;
        cont_min_next   = cont_min_reg;
        s1_valid_next   = 1'b0;
        s1_u_next       = u_reg;
        s1_sq_next      = SW'(free_cells) * SW'(free_cells);
        min_cost_next   = min_cost_reg;
        too_long_next   = too_long_reg;
        wr_en           = 1'b0;
        wr_addr         = s1_target[AW-1:0];
        wr_data         = s1_cost;

        // Configuration write
        if (cfg_write_enable)
        begin
            line_width_next = cfg_write_data;
        end

        // Result transfer
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Break and continue updates from the read data
        if (s1_valid_reg)
        begin
            brk_min_next = cost_min(brk_min_reg, s1_brk);
            if (s1_fits)
            begin
                wr_en         = 1'b1;
                cont_min_next = cost_min(cont_min_reg, s1_cost);
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (word_take)
                begin
                    len_next      = AW'(word_length);
                    last_next     = last_word;
                    bad_next      = word_bad;
                    u_next        = '0;
                    brk_min_next  = COST_UNREACH;
                    cont_min_next = COST_UNREACH;
                    if (word_bad || first_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // One table read per used-cell count
                s1_valid_next = 1'b1;
                if (u_reg == width_eff)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    u_next = u_reg + AW'(1);
                end
            end

            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!last_reg || out_free)
                begin
                    // Entry at the word's own length: start of a new line
                    if (bad_reg)
                    begin
                        cur_ok_next = 1'b0;
                        err_next    = 1'b1;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = len_reg;
                        wr_data     = first_reg ? '0 : brk_min_reg;
                        cur_ok_next = 1'b1;
                        cur_lo_next = len_reg;
                        cur_hi_next = first_reg ? len_reg : width_eff;
                    end
                    first_next    = 1'b0;
                    bank_sel_next = !bank_sel_reg;

                    if (last_reg)
                    begin
                        out_valid_next = 1'b1;
                        too_long_next  = err_reg || bad_reg;
                        if (bad_reg)
                        begin
                            min_cost_next = COST_UNREACH;
                        end
                        else if (first_reg)
                        begin
                            min_cost_next = '0;
                        end
                        else
                        begin
                            min_cost_next = cost_min(brk_min_reg, cont_min_reg);
                        end
                        // New text
                        first_next    = 1'b1;
                        err_next      = 1'b0;
                        bank_sel_next = 1'b0;
                        cur_ok_next   = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            line_width_reg <= LINE_WIDTH_RST;
            first_reg      <= 1'b1;
            err_reg        <= 1'b0;
            bank_sel_reg   <= 1'b0;
            cur_ok_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            line_width_reg <= line_width_next;
            first_reg      <= first_next;
            err_reg        <= err_next;
            bank_sel_reg   <= bank_sel_next;
            cur_ok_reg     <= cur_ok_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
        bad_reg      <= bad_next;
        cur_lo_reg   <= cur_lo_next;
        cur_hi_reg   <= cur_hi_next;
        brk_min_reg  <= brk_min_next;
        cont_min_reg <= cont_min_next;
        s1_u_reg     <= s1_u_next;
        s1_sq_reg    <= s1_sq_next;
        min_cost_reg <= min_cost_next;
        too_long_reg <= too_long_next;
    end

    // Ping-pong cost tables: read the current one, write the other
    mrww_cost_bank #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank_a (
        .clk     (clk),
        .wr_en   (wr_en && bank_sel_reg),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (a_rd_data)
    );

    mrww_cost_bank #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_bank_b (
        .clk     (clk),
        .wr_en   (wr_en && !bank_sel_reg),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (b_rd_data)
    );

    assign result_valid = out_valid_reg;
    assign min_cost     = min_cost_reg;
    assign too_long     = too_long_reg;

endmodule
